[sv/tdpt_pkg.sv]
// Shared types for the trial-division prime tester.
// No dependencies; used by the front, back and top level.
package tdpt_pkg;

    typedef enum logic [1:0] {
        KIND_NOT_PRIME,
        KIND_PRIME,
        KIND_TEST
    } kind_t;

    localparam int unsigned KIND_W = 2;

endpackage

[sv/trial_division_prime_test_top.sv]
// Top level of the trial-division prime tester: front, queue and back.
// Depends on tdpt_pkg, tdpt_front, tdpt_fifo and tdpt_back.
//
// Each candidate yields one beat with the candidate echoed and a prime flag.
// Zero, one, two, three and even candidates are settled in the front stage.
// Odd candidates of five and up go through a serial remainder unit that
// takes one candidate bit per cycle; each odd divisor d from three upward
// is tried while d * d <= candidate, and a composite stops at its smallest
// odd factor. A two-entry queue lets the front keep accepting while the back
// is busy, and the output register holds a finished result while the next
// one is computed.
module trial_division_prime_test_top #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((VALUE_WIDTH + 7) / 8)*8-1:0] s_tdata,  // candidate
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((VALUE_WIDTH + 7) / 8)*8-1:0] m_tdata,  // tested_value
    output logic                                 m_tuser   // is_prime
);

    localparam int unsigned TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int unsigned Q_W     = VALUE_WIDTH + tdpt_pkg::KIND_W;

    logic                   f_valid;
    logic                   f_ready;
    logic [VALUE_WIDTH-1:0] f_value;
    tdpt_pkg::kind_t        f_kind;
    logic                   q_valid;
    logic                   q_ready;
    logic [Q_W-1:0]         q_data;
    logic [VALUE_WIDTH-1:0] b_value;

    tdpt_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VALUE_WIDTH-1:0]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_value (f_value),
        .out_kind  (f_kind)
    );

    tdpt_fifo #(
        .DATA_W(Q_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_kind, f_value}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    tdpt_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_value  (q_data[VALUE_WIDTH-1:0]),
        .in_kind   (tdpt_pkg::kind_t'(q_data[Q_W-1:VALUE_WIDTH])),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (b_value),
        .out_prime (m_tuser)
    );

    assign m_tdata = TDATA_W'(b_value);

endmodule

[sv/tdpt_front.sv]
// Front stage: accepts candidates and sorts out the trivial cases.
// Depends on tdpt_pkg for the classification codes.
module tdpt_front #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [VALUE_WIDTH-1:0]   in_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [VALUE_WIDTH-1:0]   out_value,
    output tdpt_pkg::kind_t          out_kind
);

    logic                   valid_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    tdpt_pkg::kind_t        kind_reg;
    tdpt_pkg::kind_t        kind_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_value = value_reg;
    assign out_kind  = kind_reg;

    always_comb begin
        if (in_value[VALUE_WIDTH-1:1] == '0) begin
            kind_next = tdpt_pkg::KIND_NOT_PRIME;
        end else if (in_value[VALUE_WIDTH-1:2] == '0) begin
            kind_next = tdpt_pkg::KIND_PRIME;
        end else if (!in_value[0]) begin
            kind_next = tdpt_pkg::KIND_NOT_PRIME;
        end else begin
            kind_next = tdpt_pkg::KIND_TEST;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            value_reg <= in_value;
            kind_reg  <= kind_next;
        end
    end

endmodule

[sv/tdpt_fifo.sv]
// Two-entry queue between the front and back stages.
// No dependencies.
module tdpt_fifo #(
    parameter int unsigned DATA_W = 34
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[sv/tdpt_back.sv]
// Back stage: trial division over odd divisors with a bit-serial remainder
// unit, plus the output register. Depends on tdpt_pkg for the codes.
module tdpt_back #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [VALUE_WIDTH-1:0]   in_value,
    input  tdpt_pkg::kind_t          in_kind,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [VALUE_WIDTH-1:0]   out_value,
    output logic                     out_prime
);

    localparam int unsigned DW = (VALUE_WIDTH + 1) / 2 + 2;
    localparam int unsigned SW = VALUE_WIDTH + 2;
    localparam int unsigned CW = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHECK,
        B_DIV,
        B_NEXT,
        B_HOLD
    } state_t;

    state_t                 state_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [VALUE_WIDTH-1:0] dvd_reg;
    logic [DW-1:0]          rem_reg;
    logic [DW-1:0]          div_reg;
    logic [SW-1:0]          sq_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   prime_reg;
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic                   out_prime_reg;

    logic [DW:0]            trial;
    logic [DW:0]            rem_next;
    logic                   out_free;

    assign in_ready  = (state_reg == B_IDLE);
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_prime = out_prime_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb begin
        trial = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = trial - {1'b0, div_reg};
        end else begin
            rem_next = trial;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready && state_reg != B_HOLD) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (in_valid) begin
                        val_reg <= in_value;
                        div_reg <= DW'(3);
                        sq_reg  <= SW'(9);
                        case (in_kind)
                            tdpt_pkg::KIND_TEST: begin
                                state_reg <= B_CHECK;
                            end
                            tdpt_pkg::KIND_PRIME: begin
                                prime_reg <= 1'b1;
                                state_reg <= B_HOLD;
                            end
                            default: begin
                                prime_reg <= 1'b0;
                                state_reg <= B_HOLD;
                            end
                        endcase
                    end
                end
                B_CHECK: begin
                    if (sq_reg > SW'(val_reg)) begin
                        prime_reg <= 1'b1;
                        state_reg <= B_HOLD;
                    end else begin
                        dvd_reg   <= val_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= CW'(VALUE_WIDTH - 1);
                        state_reg <= B_DIV;
                    end
                end
                B_DIV: begin
                    rem_reg <= rem_next[DW-1:0];
                    dvd_reg <= {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == '0) begin
                        state_reg <= B_NEXT;
                    end
                end
                B_NEXT: begin
                    if (rem_reg == '0) begin
                        prime_reg <= 1'b0;
                        state_reg <= B_HOLD;
                    end else begin
                        div_reg   <= div_reg + DW'(2);
                        sq_reg    <= sq_reg + SW'({div_reg, 2'b00}) + SW'(4);
                        state_reg <= B_CHECK;
                    end
                end
                B_HOLD: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= val_reg;
                        out_prime_reg <= prime_reg;
                        state_reg     <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    a_div_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIV) |-> (div_reg[0] && div_reg >= DW'(3)))
        else $error("trial divisor is not an odd number of at least three");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIV || state_reg == B_NEXT) |-> (rem_reg < div_reg))
        else $error("partial remainder reached the divisor");

    a_sq_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_CHECK) |-> (sq_reg == SW'(SW'(div_reg) * SW'(div_reg))))
        else $error("running square lost track of the divisor");

    a_hold_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_HOLD && out_free) |=> (out_valid_reg && state_reg == B_IDLE))
        else $error("finished result was not moved to the output register");

endmodule
